// File: rtl/tcc_pkg.sv
// Shared types, constants and calendar functions for the time and calendar counter.
// Used by tcc_date_logic, tcc_time_core and time_and_calendar_counter_unit.
// No dependencies.
package tcc_pkg;

  // Width of the free-running tick counter (16 to 64)
  localparam int TccTickBits = 32;

  // Field ranges
  localparam logic [5:0]  TccMinSecMax  = 6'd59;
  localparam logic [4:0]  TccHourMax24  = 5'd23;
  localparam logic [4:0]  TccHourMax12  = 5'd11;
  localparam logic [3:0]  TccMonthMax   = 4'd12;
  localparam logic [3:0]  TccMonthMin   = 4'd1;
  localparam logic [4:0]  TccDayMin     = 5'd1;
  localparam logic [13:0] TccYearMax    = 14'd9999;
  localparam logic [13:0] TccYearReset  = 14'd2000;

  // Reciprocal of 25 for the divisibility test: q = (x * Recip) >> Shift is
  // exact for every x below 4096
  localparam logic [12:0] TccRecip25    = 13'd5243;
  localparam int          TccRecipShift = 17;

  // Item kinds carried in the input tuser
  typedef enum logic {
    TCC_OP_TICK = 1'b0,
    TCC_OP_LOAD = 1'b1
  } tcc_op_e;

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
  } tcc_date_t;

  // Fields of a load item, lowest field last in the packed order
  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic        pm;
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
  } tcc_load_t;

  // Control handed from the input stage to the core
  typedef struct packed {
    logic    valid;
    tcc_op_e op;
    logic    twelve_hour;
  } tcc_step_t;

  // State after one item, as it leaves the core
  typedef struct packed {
    logic        day_rolled;
    logic [31:0] tick_count;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic        pm;
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
  } tcc_result_t;

  // Gregorian leap test; divisibility by 100 and 400 goes through y/4 mod 25
  function automatic logic tcc_is_leap(input logic [13:0] y);
    logic [11:0] quarter;
    logic [24:0] prod;
    logic [7:0]  q;
    logic [11:0] back;
    logic        div25;
    quarter = y[13:2];
    prod    = 25'(quarter) * 25'(TccRecip25);
    q       = prod[24:TccRecipShift];
    back    = 12'({q, 4'b0000}) + 12'({q, 3'b000}) + 12'(q);
    div25   = (back == quarter);
    return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
  endfunction

  // Days in a month; a month outside 1..12 counts as January
  function automatic logic [4:0] tcc_days_in(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    unique case (m)
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      4'd2:                    len = leap ? 5'd29 : 5'd28;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// File: rtl/tcc_date_logic.sv
// Date arithmetic: next-day rollover of the current date and range clamping
// of a loaded date. Depends on tcc_pkg.
module tcc_date_logic (
  input  tcc_pkg::tcc_date_t cur_date_i,
  input  tcc_pkg::tcc_date_t load_date_i,
  output tcc_pkg::tcc_date_t next_date_o,
  output tcc_pkg::tcc_date_t load_date_o
);

  logic [4:0]  cur_len;
  logic [3:0]  ld_month;
  logic [13:0] ld_year;
  logic [4:0]  ld_len;

  // Advance the current date by one day
  always_comb begin
    cur_len     = tcc_pkg::tcc_days_in(cur_date_i.month, tcc_pkg::tcc_is_leap(cur_date_i.year));
    next_date_o = cur_date_i;
    if (cur_date_i.day >= cur_len) begin
      next_date_o.day = tcc_pkg::TccDayMin;
      if (cur_date_i.month >= tcc_pkg::TccMonthMax) begin
        next_date_o.month = tcc_pkg::TccMonthMin;
        next_date_o.year  = (cur_date_i.year >= tcc_pkg::TccYearMax) ? 14'd0
                                                                       : cur_date_i.year + 14'd1;
      end else begin
        next_date_o.month = cur_date_i.month + 4'd1;
      end
    end else begin
      next_date_o.day = cur_date_i.day + 5'd1;
    end
  end

  // Clamp a loaded date; the day is limited by the clamped month and year
  always_comb begin
    ld_month = load_date_i.month;
    if (ld_month < tcc_pkg::TccMonthMin) ld_month = tcc_pkg::TccMonthMin;
    if (ld_month > tcc_pkg::TccMonthMax) ld_month = tcc_pkg::TccMonthMax;
    ld_year = (load_date_i.year > tcc_pkg::TccYearMax) ? tcc_pkg::TccYearMax : load_date_i.year;
    ld_len  = tcc_pkg::tcc_days_in(ld_month, tcc_pkg::tcc_is_leap(ld_year));
    load_date_o.month = ld_month;
    load_date_o.year  = ld_year;
    if (load_date_i.day < tcc_pkg::TccDayMin) begin
      load_date_o.day = tcc_pkg::TccDayMin;
    end else if (load_date_i.day > ld_len) begin
      load_date_o.day = ld_len;
    end else begin
      load_date_o.day = load_date_i.day;
    end
  end

endmodule

// File: rtl/tcc_time_core.sv
// Clock and calendar state registers with the tick cascade and load logic.
// Depends on tcc_pkg and tcc_date_logic.
module tcc_time_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tcc_pkg::tcc_step_t     step_i,
  input  tcc_pkg::tcc_load_t     load_i,
  output tcc_pkg::tcc_result_t   result_o
);

  logic [4:0]  hour_q, hour_d;
  logic [5:0]  minute_q, minute_d;
  logic [5:0]  second_q, second_d;
  logic        pm_q, pm_d;
  logic [tcc_pkg::TccTickBits-1:0] cnt_q, cnt_d;
  logic [tcc_pkg::TccTickBits-1:0] cnt_one;
  tcc_pkg::tcc_date_t date_q, date_d;
  tcc_pkg::tcc_date_t next_date, load_date, raw_load_date;
  logic [4:0]  hour_max;
  logic        rolled;

  assign raw_load_date = '{day: load_i.day, month: load_i.month, year: load_i.year};

  // Counter increment at the full counter width
  assign cnt_one = {{(tcc_pkg::TccTickBits-1){1'b0}}, 1'b1};

  tcc_date_logic u_date (
    .cur_date_i  (date_q),
    .load_date_i (raw_load_date),
    .next_date_o (next_date),
    .load_date_o (load_date)
  );

  // Compute the state after the current item
  always_comb begin
    hour_max = step_i.twelve_hour ? tcc_pkg::TccHourMax12 : tcc_pkg::TccHourMax24;
    hour_d   = hour_q;
    minute_d = minute_q;
    second_d = second_q;
    pm_d     = pm_q;
    date_d   = date_q;
    cnt_d    = cnt_q;
    rolled   = 1'b0;
    if (step_i.op == tcc_pkg::TCC_OP_LOAD) begin
      hour_d   = (load_i.hour > hour_max) ? hour_max : load_i.hour;
      minute_d = (load_i.minute > tcc_pkg::TccMinSecMax) ? tcc_pkg::TccMinSecMax : load_i.minute;
      second_d = (load_i.second > tcc_pkg::TccMinSecMax) ? tcc_pkg::TccMinSecMax : load_i.second;
      pm_d     = step_i.twelve_hour & load_i.pm;
      date_d   = load_date;
    end else begin
      cnt_d = cnt_q + cnt_one;
      pm_d  = step_i.twelve_hour & pm_q;
      if (second_q < tcc_pkg::TccMinSecMax) begin
        second_d = second_q + 6'd1;
      end else begin
        second_d = 6'd0;
        if (minute_q < tcc_pkg::TccMinSecMax) begin
          minute_d = minute_q + 6'd1;
        end else begin
          minute_d = 6'd0;
          if (hour_q >= hour_max) begin
            hour_d = 5'd0;
            // 12-hour mode rolls the date only on the pm-to-am step
            if (step_i.twelve_hour) begin
              rolled = pm_q;
              pm_d   = ~pm_q;
            end else begin
              rolled = 1'b1;
            end
          end else begin
            hour_d = hour_q + 5'd1;
          end
        end
      end
      if (rolled) date_d = next_date;
    end
  end

  // Hold state until an item is applied
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hour_q   <= 5'd0;
      minute_q <= 6'd0;
      second_q <= 6'd0;
      pm_q     <= 1'b0;
      date_q   <= '{day: tcc_pkg::TccDayMin, month: tcc_pkg::TccMonthMin,
                    year: tcc_pkg::TccYearReset};
      cnt_q    <= '0;
    end else if (step_i.valid) begin
      hour_q   <= hour_d;
      minute_q <= minute_d;
      second_q <= second_d;
      pm_q     <= pm_d;
      date_q   <= date_d;
      cnt_q    <= cnt_d;
    end
  end

  assign result_o = '{
    day_rolled: rolled,
    tick_count: 32'(cnt_d),
    year:       date_d.year,
    month:      date_d.month,
    day:        date_d.day,
    pm:         pm_d,
    second:     second_d,
    minute:     minute_d,
    hour:       hour_d
  };

  // The tick counter advances by one on each tick and holds on a load
  a_tick_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i.valid && (step_i.op == tcc_pkg::TCC_OP_TICK) |=> cnt_q == $past(cnt_q) + cnt_one)
    else $error("tick counter did not advance on a tick");

  a_load_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i.valid && (step_i.op == tcc_pkg::TCC_OP_LOAD) |=> $stable(cnt_q))
    else $error("tick counter changed on a load");

  // A date rollover leaves the time at midnight
  a_roll_at_midnight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i.valid && rolled |=> (hour_q == 5'd0) && (minute_q == 6'd0) && (second_q == 6'd0))
    else $error("date advanced away from midnight");

endmodule

// File: rtl/time_and_calendar_counter_unit.sv
// Top level of the time and calendar counter: input stage, output register
// and mode register around tcc_time_core. Depends on tcc_pkg and tcc_time_core.
//
// Usage:
//   s_axis carries one item per transfer. tuser is the item kind: a one-second
//   tick or a load of time and date. On a load, tdata holds the values to
//   write; on a tick it is ignored. m_axis returns one result per item, the
//   full time, date, tick count and a flag for a date rollover.
//   The cfg channel writes the 12-hour mode bit; write it only while no item
//   is in flight. cfg_ready_o is always high.
// Flow and throughput:
//   An accepted item waits in the input stage until the result register has
//   room; it is then applied to the clock state and its result is offered on
//   m_axis. One item per cycle is sustained while m_axis_tready stays high;
//   the tick cascade, month-length lookup and leap test are combinational.
// Reset:
//   Time 00:00:00, date 2000-01-01, tick count 0, 24-hour mode, both
//   pipeline registers empty.
// Stall:
//   While the receiver holds m_axis_tready low, the result stays put, one
//   more item may wait in the input stage, and then s_axis_tready drops.
module time_and_calendar_counter_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,     // twelve_hour_mode
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [4:0] load_hour, [10:5] load_minute, [16:11] load_second, [17] load_pm,
  // [22:18] load_day, [26:23] load_month, [40:27] load_year, [47:41] zero
  input  logic [47:0] s_axis_tdata,
  input  logic        s_axis_tuser,   // [0] opcode
  // Output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [4:0] hour, [10:5] minute, [16:11] second, [17] pm, [22:18] day,
  // [26:23] month, [40:27] year, [72:41] tick_count, [73] day_rolled, [79:74] zero
  output logic [79:0] m_axis_tdata
);

  logic                 mode_q;
  logic                 in_vld_q, in_vld_d;
  tcc_pkg::tcc_op_e     in_op_q;
  tcc_pkg::tcc_load_t   in_load_q;
  logic                 out_vld_q, out_vld_d;
  tcc_pkg::tcc_result_t out_q;
  tcc_pkg::tcc_result_t result;
  tcc_pkg::tcc_step_t   step;
  logic                 advance;
  logic                 s_fire;

  // Mode register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_valid_i) begin
      mode_q <= cfg_data_i;
    end
  end

  // Move the staged item into the result register when it has room
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_vld_d = in_vld_q;
    if (s_fire) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (advance) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Capture the input transfer
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_op_q   <= tcc_pkg::tcc_op_e'(s_axis_tuser);
      in_load_q <= tcc_pkg::tcc_load_t'(s_axis_tdata[40:0]);
    end
  end

  assign step = '{valid: advance, op: in_op_q, twelve_hour: mode_q};

  tcc_time_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .load_i   (in_load_q),
    .result_o (result)
  );

  // Hold the result until the receiver takes it
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'd0, out_q};

endmodule
